### rtl/xs1024p_pkg.sv
// Shared types and constants for the xorshift1024+ generator.
// Used by the controller, datapath, register block and top level; no dependencies.
`timescale 1ns / 1ps

package xs1024p_pkg;

  localparam int WORD_W     = 64;
  localparam int WORD_COUNT = 16;
  localparam int POS_W      = $clog2(WORD_COUNT);
  localparam int ADDR_W     = 4;

  // mixing shifts
  localparam int SHIFT_A = 31;
  localparam int SHIFT_B = 11;
  localparam int SHIFT_C = 30;

  // controller to datapath commands
  typedef struct packed {
    logic read;     // capture both state words for a new request
    logic resolve;  // turn raw reads into effective words
    logic reload;   // reseed all sixteen words
    logic commit;   // write the new word, advance, present result
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic a_zero;   // current word is zero
    logic out_full; // result register occupied and not taken this cycle
  } dp_status_t;

  // constant seed word for each position
  function automatic logic [WORD_W-1:0] seed_word(input logic [POS_W-1:0] idx);
    logic [WORD_W-1:0] k;
    unique case (idx)
      4'd0:    k = 64'd3176816624292027912;
      4'd1:    k = 64'd5825261852996363023;
      4'd2:    k = 64'd2657966707352449287;
      4'd3:    k = 64'd1350174793163142913;
      4'd4:    k = 64'd3916890652982003621;
      4'd5:    k = 64'd8441565361753670199;
      4'd6:    k = 64'd4048287511883088063;
      4'd7:    k = 64'd7692991216032604145;
      4'd8:    k = 64'd9168990544929416867;
      4'd9:    k = 64'd4210552781383542944;
      4'd10:   k = 64'd1295553278952537540;
      4'd11:   k = 64'd4600491088959978208;
      4'd12:   k = 64'd1426091184381835091;
      4'd13:   k = 64'd2349336915254555439;
      4'd14:   k = 64'd2525507937445642803;
      default: k = 64'd4828313259052508846;
    endcase
    return k;
  endfunction

endpackage

### rtl/xs1024p_regs.sv
// APB-style configuration register block holding the seed offset.
// Depends on xs1024p_pkg.
`timescale 1ns / 1ps

module xs1024p_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [xs1024p_pkg::ADDR_W-1:0]  paddr,
  input  logic [xs1024p_pkg::WORD_W-1:0]  pwdata,
  output logic [xs1024p_pkg::WORD_W-1:0]  prdata,
  output logic                            pready,
  output logic [xs1024p_pkg::WORD_W-1:0]  seed_offset
);
  import xs1024p_pkg::*;

  logic [WORD_W-1:0] seed_offset_r;
  logic [WORD_W-1:0] seed_offset_nxt;
  logic              hit;
  logic              wr_en;

  // decode: the single register answers at byte addresses 0 to 7 (paddr[3] low)
  assign hit    = (paddr[ADDR_W-1] == 1'b0);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && hit;

  // update on a completed write access
  always_comb begin
    seed_offset_nxt = seed_offset_r;
    if (wr_en) begin
      seed_offset_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_offset_r <= '0;
    end else begin
      seed_offset_r <= seed_offset_nxt;
    end
  end

  // read back
  assign prdata      = hit ? seed_offset_r : '0;
  assign seed_offset = seed_offset_r;

endmodule

### rtl/xs1024p_ctrl.sv
// Controller state machine sequencing read, resolve, reseed and commit steps.
// Depends on xs1024p_pkg.
`timescale 1ns / 1ps

module xs1024p_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_draw,
  input  xs1024p_pkg::dp_status_t status,
  output xs1024p_pkg::ctrl_cmd_t  cmd
);
  import xs1024p_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RESOLVE = 2'd1;
  localparam logic [1:0] ST_MIX     = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       reloaded_r;
  logic       reloaded_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    reloaded_nxt = reloaded_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        // drop requests with draw low, start the rest
        if (in_valid && in_draw) begin
          cmd.read  = 1'b1;
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        cmd.resolve  = 1'b1;
        reloaded_nxt = 1'b0;
        state_nxt    = ST_MIX;
      end
      ST_MIX: begin
        // reseed at most once per request, then wait for a free result slot
        if (status.a_zero && !reloaded_r) begin
          cmd.reload   = 1'b1;
          reloaded_nxt = 1'b1;
        end else if (!status.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      reloaded_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      reloaded_r <= reloaded_nxt;
    end
  end

endmodule

### rtl/xs1024p_dpath.sv
// Datapath: state word memory with per-word valid bits, position, mixer and
// result register. Depends on xs1024p_pkg.
`timescale 1ns / 1ps

module xs1024p_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  xs1024p_pkg::ctrl_cmd_t         cmd,
  output xs1024p_pkg::dp_status_t        status,
  input  logic [xs1024p_pkg::WORD_W-1:0] seed_offset,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [xs1024p_pkg::WORD_W-1:0] out_random_value
);
  import xs1024p_pkg::*;

  // state word memory, two registered read ports, one write port
  logic [WORD_W-1:0] mem [WORD_COUNT];
  logic [WORD_W-1:0] rd_a_r;
  logic [WORD_W-1:0] rd_b_r;

  // control state
  logic [WORD_COUNT-1:0] valid_r;
  logic [WORD_COUNT-1:0] valid_nxt;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_nxt;
  logic                  seeded_r;
  logic                  seeded_nxt;
  logic                  va_r;
  logic                  vb_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  // payload
  logic [WORD_W-1:0] snap_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WORD_W-1:0] out_data_r;

  logic [POS_W-1:0]  next_pos;
  logic [WORD_W-1:0] fill_a;
  logic [WORD_W-1:0] fill_b;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] w;

  assign next_pos = pos_r + 1'b1;

  // value of a word that was never written since the last reseed
  assign fill_a = seeded_r ? (seed_word(pos_r) + snap_r) : '0;
  assign fill_b = seeded_r ? (seed_word(next_pos) + snap_r) : '0;

  // mix
  assign t = b_r ^ (b_r << SHIFT_A);
  assign w = t ^ a_r ^ (t >> SHIFT_B) ^ (a_r >> SHIFT_C);

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[next_pos] <= w;
    end
    if (cmd.read) begin
      rd_a_r <= mem[pos_r];
      rd_b_r <= mem[next_pos];
    end
  end

  // control next values
  always_comb begin
    valid_nxt     = valid_r;
    pos_nxt       = pos_r;
    seeded_nxt    = seeded_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.reload) begin
      valid_nxt  = '0;
      seeded_nxt = 1'b1;
    end
    if (cmd.commit) begin
      valid_nxt[next_pos] = 1'b1;
      pos_nxt             = next_pos;
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      pos_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      pos_r       <= pos_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.read) begin
        va_r <= valid_r[pos_r];
        vb_r <= valid_r[next_pos];
      end
    end
  end

  // working words: resolve raw reads, or load seed values on a reseed
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      a_r <= va_r ? rd_a_r : fill_a;
      b_r <= vb_r ? rd_b_r : fill_b;
    end else if (cmd.reload) begin
      a_r    <= seed_word(pos_r) + seed_offset;
      b_r    <= seed_word(next_pos) + seed_offset;
      snap_r <= seed_offset;
    end
    if (cmd.commit) begin
      out_data_r <= w + b_r;
    end
  end

  assign status.a_zero   = (a_r == '0);
  assign status.out_full = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_random_value = out_data_r;

endmodule

### rtl/xorshift1024_plus_generator.sv
// xorshift1024+ generator: each request with in_draw high returns one 64-bit
// word; a request with in_draw low is taken and gives no result. Both state
// words are read through the memory's registered read ports in the accepting
// cycle. They are resolved against the per-word valid bits in the next cycle.
// In the mix state they are then mixed, written back and registered as the
// result, which raises out_valid. When the word at the current position is
// zero, all sixteen words are reseeded first. The reseed clears all valid
// bits together, so there is no clearing sweep after reset. The last step
// also waits while an earlier result is still held on the output and not
// taken. The next request is taken the cycle after the result is registered,
// while that result still waits on the output. The seed offset register sits
// at byte address 0 of the APB-style port and should be written only while
// no request is in flight.
// Depends on xs1024p_pkg, xs1024p_regs, xs1024p_ctrl and xs1024p_dpath.
`timescale 1ns / 1ps

module xorshift1024_plus_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_draw,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [xs1024p_pkg::WORD_W-1:0] out_random_value,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [xs1024p_pkg::ADDR_W-1:0] paddr,
  input  logic [xs1024p_pkg::WORD_W-1:0] pwdata,
  output logic [xs1024p_pkg::WORD_W-1:0] prdata,
  output logic                           pready
);
  import xs1024p_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [WORD_W-1:0] seed_offset;

  xs1024p_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .seed_offset (seed_offset)
  );

  xs1024p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_draw  (in_draw),
    .status   (status),
    .cmd      (cmd)
  );

  xs1024p_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .seed_offset      (seed_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

endmodule
